// ===== src/kli_pkg.sv =====
// Package for the keyframe linear interpolator.
// Shared constants, operation codes and the divider sideband type.
// No dependencies.
package kli_pkg;

    localparam int MAX_KEYS_DEF = 16;
    localparam int QW           = 33;   // quotient bits: |to - from| < 2**33
    localparam int PW           = QW + 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAST  = 2'd0,
        KIND_HIT   = 2'd1,
        KIND_FIRST = 2'd2,
        KIND_SEG   = 2'd3
    } kind_t;

    // Travels alongside the divider
    typedef struct packed {
        logic               direct;
        logic               empty;
        logic               neg;
        logic signed [31:0] from;
        logic signed [31:0] dval;
    } kli_side_t;

endpackage

// ===== src/kli_ifs.sv =====
// Input and output channel interfaces of the keyframe linear interpolator.
// Depends on nothing outside this file.
interface kli_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [3:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] key_value;
    logic signed [31:0] start_value;
    logic [31:0]        current_time;

    modport source (output valid, opcode, key_index, key_time, key_value, start_value,
                    current_time, input ready);
    modport sink (input valid, opcode, key_index, key_time, key_value, start_value,
                  current_time, output ready);
endinterface

interface kli_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               table_empty;

    modport source (output valid, result_value, table_empty, input ready);
    modport sink (input valid, result_value, table_empty, output ready);
endinterface

// ===== src/kli_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on kli_pkg.
module kli_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [kli_pkg::PW-1:0] in_prod,
    input  logic [31:0]       in_span,
    input  kli_pkg::kli_side_t in_side,
    output logic              out_valid,
    output logic [kli_pkg::QW-1:0] out_q,
    output logic [31:0]       out_r,
    output logic [31:0]       out_span,
    output kli_pkg::kli_side_t out_side
);
    import kli_pkg::*;

    logic [QW:0]     v_reg;
    logic [31:0]     r_reg    [0:QW];
    logic [QW-1:0]   q_reg    [0:QW];
    logic [31:0]     span_reg [0:QW];
    kli_side_t       side_reg [0:QW];
    logic [31:0]     r_next   [1:QW];
    logic [QW-1:0]   q_next   [1:QW];

    // One trial subtraction per stage
    always_comb
    begin
        logic [32:0] trial;
        for (int k = 1; k <= QW; k++)
        begin
            trial = {r_reg[k-1], q_reg[k-1][QW-1]};
            if (trial >= {1'b0, span_reg[k-1]})
            begin
                r_next[k] = 32'(trial - {1'b0, span_reg[k-1]});
                q_next[k] = {q_reg[k-1][QW-2:0], 1'b1};
            end
            else
            begin
                r_next[k] = trial[31:0];
                q_next[k] = {q_reg[k-1][QW-2:0], 1'b0};
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QW-1:0], in_valid};
    end

    // Advance stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= in_prod[PW-1:QW];
            q_reg[0]    <= in_prod[QW-1:0];
            span_reg[0] <= in_span;
            side_reg[0] <= in_side;
            for (int k = 1; k <= QW; k++)
            begin
                r_reg[k]    <= r_next[k];
                q_reg[k]    <= q_next[k];
                span_reg[k] <= span_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_q     = q_reg[QW];
    assign out_r     = r_reg[QW];
    assign out_span  = span_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

// ===== src/keyframe_linear_interpolator.sv =====
// Keyframe linear interpolator: key table, search and exact rounded interpolation.
// Pipeline: 5 stages, 34 divider stages, output.
// Throughput: one transaction per cycle unless stalled; the 33-stage bit-per-stage divider
// sets the depth. An evaluate waits while a table write sits in stage 1 or 2.
// A stalled output holds every stage; nothing is dropped or repeated.
// Reset clears key_count and all valid bits; table contents stay undefined until written.
// Depends on kli_pkg, kli_ifs and kli_div.
module keyframe_linear_interpolator #(
    parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    kli_in_if.sink      in_ch,
    kli_out_if.source   out_ch
);
    import kli_pkg::*;

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    logic                     en;
    logic                     wr_pend;
    logic [4:0]               key_count_reg;
    logic [31:0]              time_tbl_reg  [0:MAX_KEYS-1];
    logic signed [31:0]       value_tbl_reg [0:MAX_KEYS-1];
    logic [CNT_W-1:0]         n_c;

    // stage 1
    logic s1_v_reg, s1_op_reg;
    logic [3:0] s1_kidx_reg;
    logic [31:0] s1_ktime_reg, s1_t_reg;
    logic signed [31:0] s1_kval_reg, s1_start_reg;
    logic [MAX_KEYS-1:0] ge_c, eq_c;
    // stage 2
    logic s2_v_reg, s2_op_reg;
    logic [3:0] s2_kidx_reg;
    logic [31:0] s2_ktime_reg, s2_t_reg;
    logic signed [31:0] s2_kval_reg, s2_start_reg;
    logic [CNT_W-1:0] s2_n_reg;
    logic [MAX_KEYS-1:0] s2_ge_reg, s2_eq_reg;
    logic [CNT_W-1:0] idx_c;
    kind_t kind_c;
    // stage 3
    logic s3_v_reg, s3_op_reg;
    logic [3:0] s3_kidx_reg;
    logic [31:0] s3_ktime_reg, s3_t_reg;
    logic signed [31:0] s3_kval_reg, s3_start_reg;
    logic [CNT_W-1:0] s3_n_reg, s3_idx_reg;
    kind_t s3_kind_reg;
    logic [IDX_W-1:0] ix_c, ixm_c, last_c;
    logic [31:0] prev_t_c;
    // stage 4
    logic s4_v_reg, s4_direct_reg, s4_empty_reg;
    logic signed [31:0] s4_dval_reg, s4_from_reg, s4_to_reg;
    logic [31:0] s4_el_reg, s4_span_reg;
    logic signed [32:0] diff_c;
    // stage 5
    logic s5_v_reg;
    kli_side_t s5_side_reg;
    logic [32:0] s5_mag_reg;
    logic [31:0] s5_el_reg, s5_span_reg;
    // divider out
    logic dv_valid;
    logic [QW-1:0] dv_q;
    logic [31:0] dv_r, dv_span;
    kli_side_t dv_side;
    logic [QW:0] qf_c;
    logic signed [34:0] delta_c;
    logic signed [31:0] res_c;
    // output
    logic out_valid_reg, out_empty_reg;
    logic signed [31:0] out_result_reg;

    // Hold an evaluate until every earlier table write has committed
    assign wr_pend     = (s1_v_reg && (s1_op_reg == OP_WRITE))
                         || (s2_v_reg && (s2_op_reg == OP_WRITE));
    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en && !(wr_pend && (in_ch.opcode == OP_EVAL));

    // Hold the key count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_count_reg <= '0;
        else if (cfg_we)
            key_count_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (32'(key_count_reg) > 32'(MAX_KEYS))
            n_c = CNT_W'(MAX_KEYS);
        else
            n_c = CNT_W'(key_count_reg);
    end

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_ch.valid && in_ch.ready;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg && (s3_op_reg == OP_EVAL);
            s5_v_reg <= s4_v_reg;
        end
    end

    // Compare the time against every entry
    always_comb
    begin
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            ge_c[i] = (i < int'(n_c)) && (s1_t_reg <= time_tbl_reg[i]);
            eq_c[i] = (i < int'(n_c)) && (s1_t_reg == time_tbl_reg[i]);
        end
    end

    // Find the segment: first entry not below the time, then skip equal entries
    always_comb
    begin
        logic             found;
        logic             run;
        logic [CNT_W-1:0] idx1;
        found = 1'b0;
        run   = 1'b1;
        idx1  = s2_n_reg;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            if (!found && s2_ge_reg[i])
            begin
                idx1  = CNT_W'(i);
                found = 1'b1;
            end
        end
        idx_c = idx1;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            if (found && i > int'(idx1))
            begin
                if (run && s2_eq_reg[i])
                    idx_c = CNT_W'(i);
                else
                    run = 1'b0;
            end
        end
        if (!found)
            kind_c = KIND_PAST;
        else if (s2_eq_reg[idx_c[IDX_W-1:0]])
            kind_c = KIND_HIT;
        else if (idx1 == '0)
            kind_c = KIND_FIRST;
        else
            kind_c = KIND_SEG;
    end

    // Table reads for the segment ends
    assign ix_c     = s3_idx_reg[IDX_W-1:0];
    assign ixm_c    = ix_c - 1'b1;
    assign last_c   = IDX_W'(s3_n_reg - 1'b1);
    assign prev_t_c = (s3_kind_reg == KIND_FIRST) ? 32'd0 : time_tbl_reg[ixm_c];

    // Signed difference of the end values
    assign diff_c = 33'(s4_to_reg) - 33'(s4_from_reg);

    // Round half away from zero, apply sign and add the origin
    assign qf_c    = {1'b0, dv_q} + (({dv_r, 1'b0} >= {1'b0, dv_span}) ? 1'b1 : 1'b0);
    assign delta_c = dv_side.neg ? -$signed({1'b0, qf_c}) : $signed({1'b0, qf_c});
    assign res_c   = dv_side.direct ? dv_side.dval
                                    : 32'(35'(dv_side.from) + delta_c);

    // Advance payload of the front stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg    <= in_ch.opcode;
            s1_kidx_reg  <= in_ch.key_index;
            s1_ktime_reg <= in_ch.key_time;
            s1_kval_reg  <= in_ch.key_value;
            s1_start_reg <= in_ch.start_value;
            s1_t_reg     <= in_ch.current_time;

            s2_op_reg    <= s1_op_reg;
            s2_kidx_reg  <= s1_kidx_reg;
            s2_ktime_reg <= s1_ktime_reg;
            s2_kval_reg  <= s1_kval_reg;
            s2_start_reg <= s1_start_reg;
            s2_t_reg     <= s1_t_reg;
            s2_n_reg     <= n_c;
            s2_ge_reg    <= ge_c;
            s2_eq_reg    <= eq_c;

            s3_op_reg    <= s2_op_reg;
            s3_kidx_reg  <= s2_kidx_reg;
            s3_ktime_reg <= s2_ktime_reg;
            s3_kval_reg  <= s2_kval_reg;
            s3_start_reg <= s2_start_reg;
            s3_t_reg     <= s2_t_reg;
            s3_n_reg     <= s2_n_reg;
            s3_idx_reg   <= idx_c;
            s3_kind_reg  <= kind_c;

            s4_empty_reg  <= (s3_n_reg == '0);
            s4_direct_reg <= (s3_n_reg == '0) || (s3_kind_reg == KIND_PAST)
                             || (s3_kind_reg == KIND_HIT);
            if (s3_n_reg == '0)
                s4_dval_reg <= s3_start_reg;
            else if (s3_kind_reg == KIND_PAST)
                s4_dval_reg <= value_tbl_reg[last_c];
            else
                s4_dval_reg <= value_tbl_reg[ix_c];
            s4_from_reg <= (s3_kind_reg == KIND_FIRST) ? s3_start_reg : value_tbl_reg[ixm_c];
            s4_to_reg   <= value_tbl_reg[ix_c];
            s4_el_reg   <= s3_t_reg - prev_t_c;
            s4_span_reg <= time_tbl_reg[ix_c] - prev_t_c;

            s5_side_reg.direct <= s4_direct_reg;
            s5_side_reg.empty  <= s4_empty_reg;
            s5_side_reg.neg    <= diff_c[32];
            s5_side_reg.from   <= s4_from_reg;
            s5_side_reg.dval   <= s4_dval_reg;
            s5_mag_reg  <= diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
            s5_el_reg   <= (s4_el_reg > s4_span_reg) ? s4_span_reg : s4_el_reg;
            s5_span_reg <= s4_span_reg;
        end
    end

    // Commit table writes as they leave stage 3, after all earlier reads
    always_ff @(posedge clk)
    begin
        if (en && s3_v_reg && (s3_op_reg == OP_WRITE) && (32'(s3_kidx_reg) < 32'(MAX_KEYS)))
        begin
            time_tbl_reg[IDX_W'(32'(s3_kidx_reg))]  <= s3_ktime_reg;
            value_tbl_reg[IDX_W'(32'(s3_kidx_reg))] <= s3_kval_reg;
        end
    end

    kli_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_v_reg),
        .in_prod   (PW'(s5_mag_reg) * PW'(s5_el_reg)),
        .in_span   (s5_span_reg),
        .in_side   (s5_side_reg),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_r     (dv_r),
        .out_span  (dv_span),
        .out_side  (dv_side)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_result_reg <= res_c;
            out_empty_reg  <= dv_side.empty;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_result_reg;
    assign out_ch.table_empty  = out_empty_reg;

    // Divider remainder stays below the span for interpolated transactions
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && !dv_side.direct |-> dv_r < dv_span)
        else $error("divider remainder not below span");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_result_reg))
        else $error("stalled result changed");

    // Empty flag only on a direct result
    a_empty_direct: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && dv_side.empty |-> dv_side.direct)
        else $error("empty table result not direct");

endmodule
